@@ rtl/scba_pkg.sv @@
// Shared types, widths and codes for the size-class block allocator.
// No dependencies; every other file of the block imports this package.
package scba_pkg;

  localparam int ARENA_GRANULES_DEF = 65536;
  localparam int NUM_CLASSES_DEF    = 14;

  localparam int ADDR_W    = 48;
  localparam int SIZE_W    = 32;
  localparam int LIMIT_W   = 21;
  localparam int STATUS_W  = 3;
  localparam int OUT_CLS_W = 4;
  localparam int CLS_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int HDR_BYTES = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'h100000;

  typedef enum logic [STATUS_W-1:0] {
    ST_CARVED    = 3'd0,
    ST_RECYCLED  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_FREED     = 3'd4,
    ST_FOREIGN   = 3'd5,
    ST_NULL      = 3'd6
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARENA_BASE  = 1'b0,
    REG_ARENA_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic clear_wr;
    logic load_req;
    logic exec1;
    logic exec2;
    logic out_live;
    logic out_held;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } sts_t;

  // Largest request size that fits class c once the header is added.
  function automatic logic [SIZE_W-1:0] class_cap(input int c);
    logic [SIZE_W:0] cap;
    cap = (33'(HDR_BYTES) << c) - 33'(HDR_BYTES);
    return cap[SIZE_W-1:0];
  endfunction

endpackage

@@ rtl/scba_req_if.sv @@
// Request channel: allocate or free blocks with valid/ready handshake.
// Depends on scba_pkg for field widths.
interface scba_req_if;
  import scba_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, output func, output req_size, output free_addr, input ready);
  modport sink   (input valid, input func, input req_size, input free_addr, output ready);
endinterface

@@ rtl/scba_rsp_if.sv @@
// Result channel: one status word per request, valid/ready handshake.
// Depends on scba_pkg for field widths.
interface scba_rsp_if;
  import scba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ADDR_W-1:0]    payload_addr;
  logic [OUT_CLS_W-1:0] blk_class;

  modport source (output valid, output status, output payload_addr, output blk_class,
                  input ready);
  modport sink   (input valid, input status, input payload_addr, input blk_class,
                  output ready);
endinterface

@@ rtl/scba_cfg_if.sv @@
// Configuration write channel: register index and data, valid/ready handshake.
// Depends on scba_pkg for field widths.
interface scba_cfg_if;
  import scba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/scba_ctrl.sv @@
// Sequencer for the allocator: tag clearing pass, two execute steps, result hold.
// Depends on scba_pkg for the command and status structs.
module scba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  scba_pkg::sts_t sts,
  output scba_pkg::cmd_t cmd
);
  import scba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC1,
    S_EXEC2,
    S_WAIT
  } state_t;

  state_t state;
  logic   accept;

  always_comb begin
    case (state)
      S_IDLE:          in_ready = 1'b1;
      S_EXEC2, S_WAIT: in_ready = sts.out_free;
      default:         in_ready = 1'b0;
    endcase
    accept       = in_valid && in_ready;
    cmd.clear_wr = (state == S_CLEAR);
    cmd.load_req = accept;
    cmd.exec1    = (state == S_EXEC1);
    cmd.exec2    = (state == S_EXEC2);
    cmd.out_live = (state == S_EXEC2) && sts.out_free;
    cmd.out_held = (state == S_WAIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sts.clear_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= S_EXEC1;
        end
        S_EXEC1: begin
          state <= S_EXEC2;
        end
        S_EXEC2, S_WAIT: begin
          if (sts.out_free) state <= accept ? S_EXEC1 : S_IDLE;
          else state <= S_WAIT;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

@@ rtl/scba_datapath.sv @@
// Allocator datapath: class select, free-list heads, bump pointer, tag and link
// memories, output register. Depends on scba_pkg; driven by scba_ctrl commands.
module scba_datapath #(
  parameter int ARENA_GRANULES = scba_pkg::ARENA_GRANULES_DEF,
  parameter int NUM_CLASSES    = scba_pkg::NUM_CLASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  scba_pkg::cmd_t                 cmd,
  output scba_pkg::sts_t                 sts,
  input  logic                           func,
  input  logic [scba_pkg::SIZE_W-1:0]    req_size,
  input  logic [scba_pkg::ADDR_W-1:0]    free_addr,
  input  logic                           cfg_valid,
  input  logic [scba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scba_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [scba_pkg::STATUS_W-1:0]  status,
  output logic [scba_pkg::ADDR_W-1:0]    payload_addr,
  output logic [scba_pkg::OUT_CLS_W-1:0] blk_class
);
  import scba_pkg::*;

  localparam int GW    = $clog2(ARENA_GRANULES);
  localparam int HW    = GW + 1;
  localparam int HIW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CMPW  = ((GW + 1 > LIMIT_W) ? GW + 1 : LIMIT_W) + 1;
  localparam int TAG_W = CLS_W + 1;

  typedef struct packed {
    status_t              st;
    logic [ADDR_W-1:0]    addr;
    logic [OUT_CLS_W-1:0] cls;
  } res_t;

  logic [ADDR_W-1:0]  arena_base;
  logic [LIMIT_W-1:0] arena_limit;

  func_t             rq_func;
  logic [SIZE_W-1:0] rq_size;
  logic [ADDR_W-1:0] rq_addr;

  logic          head_vld [NUM_CLASSES];
  logic [GW-1:0] head_g   [NUM_CLASSES];
  logic [GW:0]   bump;
  logic [GW-1:0] clr_addr;

  logic [TAG_W-1:0] tags  [ARENA_GRANULES];
  logic [HW-1:0]    links [ARENA_GRANULES];
  logic [TAG_W-1:0] tag_rdata;
  logic [HW-1:0]    link_rdata;

  logic [NUM_CLASSES-1:0] fits;
  logic [CLS_W-1:0]       cls;
  logic                   too_large;
  logic [HIW-1:0]         h_idx;
  logic                   h_vld;
  logic [GW-1:0]          h_g;
  logic [CMPW-1:0]        want;
  logic [CMPW-1:0]        usable;
  logic                   oos;
  logic [GW-1:0]          g_alloc;
  logic                   alloc_ok;
  logic [ADDR_W-1:0]      gofs;
  logic [ADDR_W-1:0]      pay;
  logic [ADDR_W-1:0]      off;
  logic                   f_null;
  logic                   f_bad;
  logic [GW-1:0]          g_free;

  logic [CLS_W-1:0] cls_q;
  logic             pop_q;
  logic             f_null_q;
  logic             f_bad_q;
  logic [GW-1:0]    g_q;
  res_t             res_q;
  res_t             held;
  res_t             live;
  res_t             out_res;

  logic [CLS_W-1:0] tcls;
  logic             tvld;
  logic             free_ok;

  logic             tag_we;
  logic [GW-1:0]    tag_wa;
  logic [TAG_W-1:0] tag_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_base  <= '0;
      arena_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ARENA_BASE:  arena_base  <= cfg_data;
        REG_ARENA_LIMIT: arena_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rq_func <= func_t'(func);
      rq_size <= req_size;
      rq_addr <= free_addr;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) fits[c] = (rq_size <= class_cap(c));
    cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fits[c]) cls = CLS_W'(c);
    end
    too_large = !fits[NUM_CLASSES-1];

    tcls    = tag_rdata[CLS_W-1:0];
    tvld    = tag_rdata[CLS_W];
    free_ok = (rq_func == FN_FREE) && !f_null_q && !f_bad_q && tvld &&
              (tcls < CLS_W'(NUM_CLASSES));

    h_idx = cmd.exec2 ? tcls[HIW-1:0] : cls[HIW-1:0];
    h_vld = head_vld[h_idx];
    h_g   = head_g[h_idx];

    want   = CMPW'(1) << cls;
    usable = CMPW'(arena_limit >> 4);
    if (usable > CMPW'(ARENA_GRANULES)) usable = CMPW'(ARENA_GRANULES);
    oos      = (CMPW'(bump) + want) > usable;
    g_alloc  = h_vld ? h_g : bump[GW-1:0];
    alloc_ok = !too_large && (h_vld || !oos);
    gofs     = ADDR_W'(g_alloc) + ADDR_W'(1);
    pay      = arena_base + (gofs << 4);

    off    = rq_addr - ADDR_W'(HDR_BYTES) - arena_base;
    f_null = (rq_addr == '0);
    f_bad  = (off[3:0] != 4'd0) || (off[ADDR_W-1:4] >= (ADDR_W-4)'(ARENA_GRANULES));
    g_free = off[GW+3:4];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec1) begin
      cls_q    <= cls;
      pop_q    <= (rq_func == FN_ALLOC) && !too_large && h_vld;
      f_null_q <= f_null;
      f_bad_q  <= f_bad;
      g_q      <= g_free;
      if (too_large) res_q <= '{st: ST_TOO_LARGE, addr: '0, cls: '0};
      else if (h_vld) res_q <= '{st: ST_RECYCLED, addr: pay, cls: cls[OUT_CLS_W-1:0]};
      else if (oos) res_q <= '{st: ST_NO_SPACE, addr: '0, cls: cls[OUT_CLS_W-1:0]};
      else res_q <= '{st: ST_CARVED, addr: pay, cls: cls[OUT_CLS_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= '0;
    end else if (cmd.exec1 && (rq_func == FN_ALLOC) && !too_large && !h_vld && !oos) begin
      bump <= (GW+1)'(CMPW'(bump) + want);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr && !sts.clear_done) begin
      clr_addr <= clr_addr + GW'(1);
    end
  end

  always_comb begin
    tag_we = 1'b0;
    tag_wa = clr_addr;
    tag_wd = '0;
    if (cmd.clear_wr) begin
      tag_we = 1'b1;
    end else if (cmd.exec1 && (rq_func == FN_ALLOC) && alloc_ok) begin
      tag_we = 1'b1;
      tag_wa = g_alloc;
      tag_wd = {1'b1, cls};
    end else if (cmd.exec2 && free_ok) begin
      tag_we = 1'b1;
      tag_wa = g_q;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tags[tag_wa] <= tag_wd;
    if (cmd.exec1) tag_rdata <= tags[g_free];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec2 && free_ok) links[g_q] <= {h_vld, h_g};
    if (cmd.exec1) link_rdata <= links[h_g];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) head_vld[c] <= 1'b0;
    end else if (cmd.exec2) begin
      if (pop_q) head_vld[cls_q[HIW-1:0]] <= link_rdata[GW];
      else if (free_ok) head_vld[tcls[HIW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec2) begin
      if (pop_q) head_g[cls_q[HIW-1:0]] <= link_rdata[GW-1:0];
      else if (free_ok) head_g[tcls[HIW-1:0]] <= g_q;
    end
  end

  always_comb begin
    if (rq_func == FN_ALLOC) live = res_q;
    else if (f_null_q) live = '{st: ST_NULL, addr: '0, cls: '0};
    else if (free_ok) live = '{st: ST_FREED, addr: '0, cls: tcls[OUT_CLS_W-1:0]};
    else live = '{st: ST_FOREIGN, addr: '0, cls: '0};
  end

  always_ff @(posedge clk) begin
    if (cmd.exec2) held <= live;
    if (cmd.out_live) out_res <= live;
    else if (cmd.out_held) out_res <= held;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_live || cmd.out_held) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status         = out_res.st;
  assign payload_addr   = out_res.addr;
  assign blk_class      = out_res.cls;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.clear_done = (clr_addr == GW'(ARENA_GRANULES - 1));

  a_bump_in_arena: assert property (@(posedge clk) disable iff (rst)
    bump <= (GW+1)'(ARENA_GRANULES))
    else $error("bump pointer beyond arena");

  a_exec_order: assert property (@(posedge clk) disable iff (rst)
    cmd.exec2 |-> $past(cmd.exec1))
    else $error("second execute step without first");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !(cmd.load_req || cmd.exec1 || cmd.out_live || cmd.out_held))
    else $error("request activity during tag clearing");

endmodule

@@ rtl/size_class_block_allocator_top.sv @@
// Top level of the size-class block allocator: joins scba_ctrl and scba_datapath.
// Depends on scba_pkg and the scba_req_if, scba_rsp_if and scba_cfg_if interfaces.
//
//   channel  dir  word
//   req      in   func, req_size, free_addr
//   rsp      out  status, payload_addr, blk_class
//   cfg      in   index, data (arena_base, arena_limit)
//
// Each request goes through exec1 and exec2: exec1 selects the class and reads
// the tag and link memories, exec2 updates the free-list heads and forms the
// result. After reset the tag memory is cleared, one entry a cycle, over all
// ARENA_GRANULES entries; req.ready stays low during that pass, cfg writes are
// taken throughout. A result waiting on rsp.ready holds the block after exec2.
module size_class_block_allocator_top #(
  parameter int ARENA_GRANULES = scba_pkg::ARENA_GRANULES_DEF,
  parameter int NUM_CLASSES    = scba_pkg::NUM_CLASSES_DEF
) (
  input logic          clk,
  input logic          rst,
  scba_req_if.sink     req,
  scba_rsp_if.source   rsp,
  scba_cfg_if.sink     cfg
);
  import scba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  scba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scba_datapath #(
    .ARENA_GRANULES (ARENA_GRANULES),
    .NUM_CLASSES    (NUM_CLASSES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (req.func),
    .req_size     (req.req_size),
    .free_addr    (req.free_addr),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .status       (rsp.status),
    .payload_addr (rsp.payload_addr),
    .blk_class    (rsp.blk_class)
  );

endmodule
